// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the framer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain property, disabled in reset.
`define E3F_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next clock.
`define E3F_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/e3f_pkg.sv =====
// ----------------------------------------------------------------------------
// e3f_pkg
// Shared types, constants and the CRC8 step for the telegram framer.
// ----------------------------------------------------------------------------
package e3f_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 4;
	localparam int unsigned FIELD_BYTES     = 4;   // payload_bytes holds 4 bytes
	localparam int unsigned POS_W           = 5;   // up to 24 bytes per frame
	localparam int unsigned CNT_W           = 3;
	localparam int unsigned REG_ADDR_W      = 3;

	localparam logic [7:0]  SYNC_BYTE     = 8'h55;
	localparam logic [7:0]  OPT_LENGTH    = 8'd7;
	localparam logic [7:0]  SUBTEL_COUNT  = 8'h03;
	localparam logic [7:0]  OPT_FILL_A    = 8'hFF;
	localparam logic [7:0]  OPT_FILL_B    = 8'h00;
	localparam logic [15:0] DATA_OVERHEAD = 16'd6;
	localparam logic [7:0]  CRC_POLY      = 8'h07;

	// register index = paddr[2]
	localparam logic REG_PKT_TYPE       = 1'b0;
	localparam logic REG_DESTINATION_ID = 1'b1;

	localparam logic [7:0]  PKT_TYPE_RST = 8'd1;
	localparam logic [31:0] DEST_ID_RST  = 32'hFFFF_FFFF;

	// controller -> datapath
	typedef struct packed {
		logic             load;   // capture the telegram word
		logic             emit;   // push byte at pos into the output register
		logic [POS_W-1:0] pos;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // output register can take a byte this cycle
		logic last_pos;   // pos is the closing data CRC
	} sts_t;

	// CRC8, poly 0x07, MSB first
	function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] din);
		logic [7:0] c;
		c = crc ^ din;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== design/e3f_if.sv =====
// ----------------------------------------------------------------------------
// e3f_if
// Valid/ready channels: telegram in, frame bytes out.
// ----------------------------------------------------------------------------
interface e3f_tel_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rorg;
	logic [2:0]  payload_count;
	logic [31:0] payload_bytes;
	logic [31:0] src_id;
	logic [7:0]  status_byte;

	modport source (
		output valid, rorg, payload_count, payload_bytes, src_id, status_byte,
		input  ready
	);
	modport sink (
		input  valid, rorg, payload_count, payload_bytes, src_id, status_byte,
		output ready
	);
endinterface

interface e3f_frm_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last;

	modport source (output valid, frame_byte, last, input ready);
	modport sink (input valid, frame_byte, last, output ready);
endinterface

// ===== design/esp3_radio_telegram_framer_top.sv =====
// ----------------------------------------------------------------------------
// esp3_radio_telegram_framer_top
// ESP3 radio telegram to serial byte frame, with header and data CRC8.
// ----------------------------------------------------------------------------
// One telegram word in gives one ESP3 frame out, one byte word per cycle
// while the sink keeps up: sync 0x55, data length (count+6, high byte
// first), optional length 7, packet type, header CRC8; then R-ORG,
// payload bytes (byte 0 first), sender ID MSB first, status, subtelegram
// count 3, destination ID MSB first, 0xFF, 0x00, and the data CRC8 flagged
// with last. Both CRCs use poly 0x07, init 0, MSB first. A payload count
// above min(MAX_PAYLOAD, 4) is clipped; a count of zero sends no payload.
// A frame is 20 + count bytes. The byte sequencer emits a single byte per
// clock into the output register whenever that register is free, and a
// new telegram is taken only once the closing CRC has been loaded there,
// so it may be accepted while that last byte still waits. Registers (APB,
// pready tied high): 0x0 pkt_type (reset 1), 0x4 destination_id (reset
// 0xFFFFFFFF); write them only while no frame is in flight.
// ----------------------------------------------------------------------------
module esp3_radio_telegram_framer_top import e3f_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	e3f_tel_if.sink               telegram,
	e3f_frm_if.source             frame,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cmd_t        cmd;
	sts_t        sts;
	logic [7:0]  pkt_type;
	logic [31:0] destination_id;

	// config registers
	e3f_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.pkt_type       (pkt_type),
		.destination_id (destination_id)
	);

	// sequencer: idle/run and byte position
	e3f_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tel_valid (telegram.valid),
		.tel_ready (telegram.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// held telegram, byte mux, CRCs, output register
	e3f_datapath #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.rorg           (telegram.rorg),
		.payload_count  (telegram.payload_count),
		.payload_bytes  (telegram.payload_bytes),
		.src_id         (telegram.src_id),
		.status_byte    (telegram.status_byte),
		.pkt_type       (pkt_type),
		.destination_id (destination_id),
		.frm_valid      (frame.valid),
		.frm_ready      (frame.ready),
		.frm_byte       (frame.frame_byte),
		.frm_last       (frame.last)
	);

endmodule

// ===== design/e3f_regs.sv =====
// ----------------------------------------------------------------------------
// e3f_regs
// APB register file: packet type and destination ID.
// ----------------------------------------------------------------------------
module e3f_regs import e3f_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output logic [7:0]            pkt_type,
	output logic [31:0]           destination_id
);

	logic        wr_en;
	logic        reg_idx;
	logic [7:0]  pkt_type_q;
	logic [31:0] destination_id_q;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[REG_ADDR_W-1];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_type_q       <= PKT_TYPE_RST;
			destination_id_q <= DEST_ID_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PKT_TYPE:       pkt_type_q       <= pwdata[7:0];
				REG_DESTINATION_ID: destination_id_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PKT_TYPE:       prdata = {24'd0, pkt_type_q};
			REG_DESTINATION_ID: prdata = destination_id_q;
			default:            prdata = 32'd0;
		endcase
	end

	assign pkt_type       = pkt_type_q;
	assign destination_id = destination_id_q;

endmodule

// ===== design/e3f_datapath.sv =====
// ----------------------------------------------------------------------------
// e3f_datapath
// Holds the telegram, selects the byte for each frame position, runs both
// CRC8s and owns the output register.
// ----------------------------------------------------------------------------
module e3f_datapath import e3f_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [7:0]  rorg,
	input  logic [2:0]  payload_count,
	input  logic [31:0] payload_bytes,
	input  logic [31:0] src_id,
	input  logic [7:0]  status_byte,
	input  logic [7:0]  pkt_type,
	input  logic [31:0] destination_id,
	output logic        frm_valid,
	input  logic        frm_ready,
	output logic [7:0]  frm_byte,
	output logic        frm_last
);

	localparam int unsigned CAP   = (MAX_PAYLOAD < FIELD_BYTES) ? MAX_PAYLOAD : FIELD_BYTES;
	localparam int unsigned PAY_W = 8 * CAP;

	// header positions
	localparam logic [POS_W-1:0] POS_SYNC   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(2);
	localparam logic [POS_W-1:0] POS_OPTLEN = POS_W'(3);
	localparam logic [POS_W-1:0] POS_PTYPE  = POS_W'(4);
	localparam logic [POS_W-1:0] POS_HCRC   = POS_W'(5);
	localparam logic [POS_W-1:0] POS_RORG   = POS_W'(6);
	localparam logic [POS_W-1:0] POS_PAY    = POS_W'(7);

	// positions after the payload
	localparam logic [POS_W-1:0] T_SND3   = POS_W'(0);
	localparam logic [POS_W-1:0] T_SND2   = POS_W'(1);
	localparam logic [POS_W-1:0] T_SND1   = POS_W'(2);
	localparam logic [POS_W-1:0] T_SND0   = POS_W'(3);
	localparam logic [POS_W-1:0] T_STATUS = POS_W'(4);
	localparam logic [POS_W-1:0] T_SUBTEL = POS_W'(5);
	localparam logic [POS_W-1:0] T_DST3   = POS_W'(6);
	localparam logic [POS_W-1:0] T_DST2   = POS_W'(7);
	localparam logic [POS_W-1:0] T_DST1   = POS_W'(8);
	localparam logic [POS_W-1:0] T_DST0   = POS_W'(9);
	localparam logic [POS_W-1:0] T_FILL_A = POS_W'(10);
	localparam logic [POS_W-1:0] T_FILL_B = POS_W'(11);
	localparam logic [POS_W-1:0] T_DCRC   = POS_W'(12);

	logic [7:0]       rorg_q;
	logic [7:0]       status_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PAY_W-1:0] payload_q;
	logic [31:0]      sender_q;
	logic [7:0]       hcrc_q;
	logic [7:0]       dcrc_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic [15:0]      dlen;
	logic [POS_W-1:0] rel;
	logic [POS_W-1:0] tail;
	logic [POS_W-1:0] cnt_ext;
	logic             in_header;
	logic             in_payload;
	logic [7:0]       pay_byte;
	logic [7:0]       cur_byte;
	logic             is_last;
	logic             hcrc_upd;
	logic             dcrc_upd;

	// telegram capture, count saturated to CAP
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rorg_q    <= rorg;
			status_q  <= status_byte;
			cnt_q     <= (payload_count > CNT_W'(CAP)) ? CNT_W'(CAP) : payload_count;
			payload_q <= payload_bytes[PAY_W-1:0];
			sender_q  <= src_id;
		end
	end

	assign cnt_ext    = POS_W'(cnt_q);
	assign dlen       = 16'(cnt_q) + DATA_OVERHEAD;
	assign rel        = cmd.pos - POS_PAY;
	assign tail       = rel - cnt_ext;
	assign in_header  = cmd.pos < POS_PAY;
	assign in_payload = !in_header && (rel < cnt_ext);
	assign is_last    = !in_header && !in_payload && (tail == T_DCRC);

	always_comb begin
		pay_byte = 8'h00;
		for (int i = 0; i < CAP; i++) begin
			if (rel == POS_W'(i)) pay_byte = payload_q[8*i +: 8];
		end
	end

	always_comb begin
		cur_byte = 8'h00;
		if (in_header) begin
			unique case (cmd.pos)
				POS_SYNC:   cur_byte = SYNC_BYTE;
				POS_LEN_HI: cur_byte = dlen[15:8];
				POS_LEN_LO: cur_byte = dlen[7:0];
				POS_OPTLEN: cur_byte = OPT_LENGTH;
				POS_PTYPE:  cur_byte = pkt_type;
				POS_HCRC:   cur_byte = hcrc_q;
				default:    cur_byte = rorg_q;
			endcase
		end else if (in_payload) begin
			cur_byte = pay_byte;
		end else begin
			unique case (tail)
				T_SND3:   cur_byte = sender_q[31:24];
				T_SND2:   cur_byte = sender_q[23:16];
				T_SND1:   cur_byte = sender_q[15:8];
				T_SND0:   cur_byte = sender_q[7:0];
				T_STATUS: cur_byte = status_q;
				T_SUBTEL: cur_byte = SUBTEL_COUNT;
				T_DST3:   cur_byte = destination_id[31:24];
				T_DST2:   cur_byte = destination_id[23:16];
				T_DST1:   cur_byte = destination_id[15:8];
				T_DST0:   cur_byte = destination_id[7:0];
				T_FILL_A: cur_byte = OPT_FILL_A;
				T_FILL_B: cur_byte = OPT_FILL_B;
				default:  cur_byte = dcrc_q;
			endcase
		end
	end

	// header CRC covers length, option length, packet type; data CRC covers R-ORG up to the closing CRC
	assign hcrc_upd = (cmd.pos >= POS_LEN_HI) && (cmd.pos <= POS_PTYPE);
	assign dcrc_upd = (cmd.pos >= POS_RORG) && !is_last;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hcrc_q <= 8'h00;
			dcrc_q <= 8'h00;
		end else if (cmd.emit) begin
			if (hcrc_upd) hcrc_q <= crc8_add(hcrc_q, cur_byte);
			if (dcrc_upd) dcrc_q <= crc8_add(dcrc_q, cur_byte);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (frm_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= cur_byte;
			out_last_q <= is_last;
		end
	end

	assign sts.out_free = !out_valid_q || frm_ready;
	assign sts.last_pos = is_last;

	assign frm_valid = out_valid_q;
	assign frm_byte  = out_byte_q;
	assign frm_last  = out_last_q;

endmodule

// ===== design/e3f_ctrl.sv =====
// ----------------------------------------------------------------------------
// e3f_ctrl
// Frame sequencer: takes a telegram, then walks the byte position.
// ----------------------------------------------------------------------------
module e3f_ctrl import e3f_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic tel_valid,
	output logic tel_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q;
	logic [POS_W-1:0] pos_q;

	assign tel_ready = (state_q == ST_IDLE);
	assign cmd.load  = tel_ready && tel_valid;
	assign cmd.emit  = (state_q == ST_RUN) && sts.out_free;
	assign cmd.pos   = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tel_valid) begin
						state_q <= ST_RUN;
						pos_q   <= '0;
					end
				end
				ST_RUN: begin
					if (sts.out_free) begin
						if (sts.last_pos) state_q <= ST_IDLE;
						else              pos_q   <= pos_q + POS_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/e3f_checker.sv =====
// ----------------------------------------------------------------------------
// e3f_checker
// Port-level checks on the framer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module e3f_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tel_valid,
	input logic       tel_ready,
	input logic       frm_valid,
	input logic       frm_ready,
	input logic [7:0] frm_byte,
	input logic       frm_last
);

	logic tel_acc;
	logic frm_acc;

	assign tel_acc = tel_valid && tel_ready;
	assign frm_acc = frm_valid && frm_ready;

	// stalled byte holds
	`E3F_ASSERT_NEXT(a_frm_hold, clk, arst_n, frm_valid && !frm_ready, frm_valid && $stable(frm_byte) && $stable(frm_last), "frame byte changed under stall")

	// busy right after taking a telegram
	`E3F_ASSERT_NEXT(a_busy_after_acc, clk, arst_n, tel_acc, !tel_ready, "telegram ready right after accept")

	// only the closing CRC may wait while a new telegram can be taken
	`E3F_ASSERT(a_ready_only_on_last, clk, arst_n, !(tel_ready && frm_valid) || frm_last, "ready while frame body pending")

	// a non-final byte leaves more of the frame to come
	`E3F_ASSERT(a_mid_frame_busy, clk, arst_n, !(frm_acc && !frm_last) || !tel_ready, "ready in the middle of a frame")

endmodule

bind esp3_radio_telegram_framer_top e3f_checker u_e3f_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.tel_valid (telegram.valid),
	.tel_ready (telegram.ready),
	.frm_valid (frame.valid),
	.frm_ready (frame.ready),
	.frm_byte  (frame.frame_byte),
	.frm_last  (frame.last)
);

// ===== tb/frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_checker
// Watches the telegram, frame and register ports, builds the expected ESP3
// frame for every accepted telegram and compares each frame word against it.
// ----------------------------------------------------------------------------
module frame_checker import e3f_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	e3f_tel_if                    tel,
	e3f_frm_if                    frm,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output int                    mismatch_count,
	output int                    words_pending
);

	localparam int unsigned PAYLOAD_CAP = (MAX_PAYLOAD < FIELD_BYTES) ? MAX_PAYLOAD : FIELD_BYTES;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last;
	} frame_word_t;

	logic [7:0]  pkt_type       = PKT_TYPE_RST;
	logic [31:0] destination_id = DEST_ID_RST;
	frame_word_t expected_words[$];
	int          mismatches     = 0;

	// bit-serial form: feedback is the top CRC bit against the next data bit
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ data[i];
			r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	function automatic void expect_word(input logic [7:0] b, input logic is_last);
		frame_word_t w;
		w.frame_byte = b;
		w.last       = is_last;
		expected_words = {expected_words, w};
	endfunction

	function automatic void queue_frame(input logic [7:0] rorg, input logic [2:0] count,
		input logic [31:0] payload, input logic [31:0] sender, input logic [7:0] status);
		logic [2:0]  n;
		logic [15:0] data_len;
		logic [7:0]  hdr[4];
		logic [7:0]  body[$];
		logic [7:0]  crc;
		n        = (count > PAYLOAD_CAP) ? 3'(PAYLOAD_CAP) : count;
		data_len = 16'(n) + DATA_OVERHEAD;
		hdr[0]   = data_len[15:8];
		hdr[1]   = data_len[7:0];
		hdr[2]   = OPT_LENGTH;
		hdr[3]   = pkt_type;

		expect_word(SYNC_BYTE, 1'b0);
		crc = 8'h00;
		for (int i = 0; i < 4; i++) begin
			crc = crc8_step(crc, hdr[i]);
			expect_word(hdr[i], 1'b0);
		end
		expect_word(crc, 1'b0);

		body = {body, rorg};
		for (int i = 0; i < n; i++)
			body = {body, payload[8*i +: 8]};
		for (int i = 3; i >= 0; i--)
			body = {body, sender[8*i +: 8]};
		body = {body, status};
		body = {body, SUBTEL_COUNT};
		for (int i = 3; i >= 0; i--)
			body = {body, destination_id[8*i +: 8]};
		body = {body, OPT_FILL_A};
		body = {body, OPT_FILL_B};

		crc = 8'h00;
		foreach (body[i]) begin
			crc = crc8_step(crc, body[i]);
			expect_word(body[i], 1'b0);
		end
		expect_word(crc, 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_word_t want;
		if (!arst_n) begin
			pkt_type       = PKT_TYPE_RST;
			destination_id = DEST_ID_RST;
			expected_words.delete();
			mismatch_count <= mismatches;
			words_pending  <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_PKT_TYPE)
					pkt_type = pwdata[7:0];
				else
					destination_id = pwdata;
			end

			// retire before queueing: a word cannot belong to a telegram taken this edge
			if (frm.valid && frm.ready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					$error("frame word with nothing expected: frame_byte %02h last %0b",
						frm.frame_byte, frm.last);
				end else begin
					want = expected_words.pop_front();
					if (frm.frame_byte !== want.frame_byte) begin
						mismatches++;
						$error("frame_byte: expected %02h, actual %02h",
							want.frame_byte, frm.frame_byte);
					end
					if (frm.last !== want.last) begin
						mismatches++;
						$error("last: expected %0b, actual %0b", want.last, frm.last);
					end
				end
			end

			if (tel.valid && tel.ready)
				queue_frame(tel.rorg, tel.payload_count, tel.payload_bytes,
					tel.src_id, tel.status_byte);

			mismatch_count <= mismatches;
			words_pending  <= expected_words.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the ESP3 telegram framer. Telegrams go in through
// the valid/ready port with random gaps, frame words come out under random
// back-pressure, and frame_checker predicts and compares every word. The
// register port is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;
	import e3f_pkg::*;

	localparam int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF;

	// worst case is roughly 180 telegrams x 25 words under heavy stalls; keep a wide margin
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 150;   // long sink stall, fills the framer
	localparam int DRAIN_CYCLES = 40;    // more than one full frame
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 25;

	localparam logic [REG_ADDR_W-1:0] ADDR_PKT_TYPE       = REG_ADDR_W'(4 * REG_PKT_TYPE);
	localparam logic [REG_ADDR_W-1:0] ADDR_DESTINATION_ID = REG_ADDR_W'(4 * REG_DESTINATION_ID);

	// common R-ORG codes
	localparam logic [7:0] RORG_SWITCH = 8'hF6;
	localparam logic [7:0] RORG_1BS    = 8'hD5;
	localparam logic [7:0] RORG_4BS    = 8'hA5;
	localparam logic [7:0] RORG_VLD    = 8'hD2;

	typedef struct {
		logic [7:0]  rorg;
		logic [2:0]  count;
		logic [31:0] payload;
		logic [31:0] sender;
		logic [7:0]  status;
	} telegram_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [REG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	int mismatch_count;
	int words_pending;
	int cycle_count;

	bit idling       = 1'b1;   // random gaps/stalls on both sides
	bit hold_request = 1'b0;   // one-shot long stall on the frame side

	e3f_tel_if tel_ch ();
	e3f_frm_if frm_ch ();

	esp3_radio_telegram_framer_top #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.telegram (tel_ch),
		.frame    (frm_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	frame_checker #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) frame_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.tel            (tel_ch),
		.frm            (frm_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.words_pending  (words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: falls through only if the run hangs
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[esp3_radio_telegram_framer_top] ERROR");
		$finish;
	end

	// frame sink: random stall bursts, one long hold on request, steady when idling is off
	initial begin
		frm_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				frm_ch.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(posedge clk);
			end else if (idling && $urandom_range(0, 4) == 0) begin
				frm_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				frm_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic telegram_t telegram(input logic [7:0] rorg, input logic [2:0] count,
		input logic [31:0] payload, input logic [31:0] sender, input logic [7:0] status);
		telegram_t t;
		t.rorg    = rorg;
		t.count   = count;
		t.payload = payload;
		t.sender  = sender;
		t.status  = status;
		return t;
	endfunction

	// mostly nominal counts; zero and oversized counts show up now and then
	function automatic telegram_t random_telegram();
		telegram_t t;
		int        pick;
		pick = $urandom_range(0, 7);
		case (pick)
			0:       t.rorg = RORG_SWITCH;
			1:       t.rorg = RORG_1BS;
			2:       t.rorg = RORG_4BS;
			3:       t.rorg = RORG_VLD;
			default: t.rorg = 8'($urandom);
		endcase
		pick = $urandom_range(0, 19);
		if (pick == 0)
			t.count = 3'd0;
		else if (pick == 1)
			t.count = 3'($urandom_range(5, 7));
		else
			t.count = 3'($urandom_range(1, 4));
		t.payload = $urandom;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			t.sender = 32'h0000_0000;
		else if (pick == 1)
			t.sender = 32'hFFFF_FFFF;
		else
			t.sender = $urandom;
		t.status = 8'($urandom);
		return t;
	endfunction

	// valid stays up between back-to-back words; it only drops inside a gap
	task automatic drive_telegram(input telegram_t t);
		if (idling && $urandom_range(0, 3) == 0) begin
			tel_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		tel_ch.rorg          <= t.rorg;
		tel_ch.payload_count <= t.count;
		tel_ch.payload_bytes <= t.payload;
		tel_ch.src_id        <= t.sender;
		tel_ch.status_byte   <= t.status;
		tel_ch.valid         <= 1'b1;
		do @(posedge clk); while (!tel_ch.ready);
	endtask

	// drop valid, then wait until every predicted frame word has come out
	task automatic wait_frames_done();
		tel_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
	endtask

	// setup phase, access phase until pready, then the bus goes idle
	task automatic write_reg(input logic [REG_ADDR_W-1:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [7:0]  pt;
		logic [31:0] dest;

		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		tel_ch.valid         = 1'b0;
		tel_ch.rorg          = '0;
		tel_ch.payload_count = '0;
		tel_ch.payload_bytes = '0;
		tel_ch.src_id        = '0;
		tel_ch.status_byte   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset register values: field extremes, zero and clipped counts
		drive_telegram(telegram(RORG_SWITCH, 3'd1, 32'h0000_0030, 32'hFEFB_1234, 8'h30));
		drive_telegram(telegram(8'h00,    3'd0, 32'h0000_0000, 32'h0000_0000, 8'h00));
		drive_telegram(telegram(8'hFF,    3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
		drive_telegram(telegram(RORG_1BS, 3'd1, 32'h0000_0009, 32'h0180_2C3A, 8'h00));
		drive_telegram(telegram(RORG_4BS, 3'd4, 32'h1234_5678, 32'h0505_0505, 8'h80));
		drive_telegram(telegram(RORG_VLD, 3'd2, 32'h0000_A55A, 32'h8000_0001, 8'h01));
		drive_telegram(telegram(RORG_VLD, 3'd3, 32'h00C3_3C96, 32'h0000_0000, 8'h0F));
		drive_telegram(telegram(8'h55,    3'd5, 32'hDEAD_BEEF, 32'h0102_0304, 8'h55));
		drive_telegram(telegram(8'hAA,    3'd6, 32'h0F0F_F0F0, 32'hA5A5_5A5A, 8'hAA));
		drive_telegram(telegram(8'h01,    3'd7, 32'hFFFF_FFFF, 32'h0000_0000, 8'h7F));
		drive_telegram(telegram(8'h80,    3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h80));
		drive_telegram(telegram(8'h7F,    3'd4, 32'h8080_8080, 32'h7F7F_7F7F, 8'hF0));
		drive_telegram(telegram(RORG_SWITCH, 3'd1, 32'h0000_0000, 32'h0000_0000, 8'h20));
		wait_frames_done();

		// random phases, each with its own register settings; the last one runs flat out
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					pt   = 8'h00;
					dest = 32'h0000_0000;
				end
				1: begin
					pt   = 8'hFF;
					dest = 32'hFFFF_FFFF;
				end
				2: begin
					pt   = PKT_TYPE_RST;
					dest = $urandom;
				end
				default: begin
					pt   = 8'($urandom);
					dest = $urandom;
				end
			endcase
			write_reg(ADDR_PKT_TYPE, {24'h0, pt});
			write_reg(ADDR_DESTINATION_ID, dest);
			if (p == 2)
				hold_request = 1'b1;   // sender keeps offering while the sink holds off
			idling = (p != PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// alternate stretches with and without gaps
				if (p != PHASES - 1 && i % 8 == 0)
					idling = ($urandom_range(0, 3) != 0);
				drive_telegram(random_telegram());
			end
			wait_frames_done();
		end

		// catch any stray words after the last frame
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && words_pending == 0)
			$display("[esp3_radio_telegram_framer_top] OK");
		else
			$display("[esp3_radio_telegram_framer_top] ERROR");
		$finish;
	end

endmodule
